/* rtl/ccpe_pkg.sv */
// Shared types, widths and constants for the cubic curve point evaluator.
// No dependencies; every other file refers to this package by scoped names.
package ccpe_pkg;

	localparam int COORD_W    = 16;
	localparam int T_W        = 17;
	localparam int T_FRAC     = 16;
	localparam int COEF_W     = 20;
	localparam int NUM_AXES   = 3;
	localparam int NUM_POINTS = 4;
	localparam int PT_IDX_W   = 2;

	localparam logic [T_W-1:0] T_ONE = 17'h1_0000;

	localparam int QUEUE_DEPTH = 4;
	localparam int PIPE_STAGES = 6;

	localparam logic REQ_LOAD     = 1'b0;
	localparam logic REQ_EVAL     = 1'b1;
	localparam logic BASIS_BEZIER = 1'b0;
	localparam logic BASIS_SPLINE = 1'b1;

	// Horner datapath widths: h1 = a*T + b*S, h2 = h1*T + c*S^2, h3 = h2*T + d*S^3
	localparam int H1W    = 37;
	localparam int SPLIT1 = 18;
	localparam int P2H_W  = H1W - SPLIT1 + T_W + 1;
	localparam int P2L_W  = SPLIT1 + T_W;
	localparam int H2W    = 54;
	localparam int SPLIT2 = 27;
	localparam int P3H_W  = H2W - SPLIT2 + T_W + 1;
	localparam int P3L_W  = SPLIT2 + T_W;
	localparam int H3W    = 71;
	localparam int R_W    = H3W - 3 * T_FRAC;

	localparam int SPLINE_BIAS = 3;
	localparam int COORD_MAX   = 32767;
	localparam int COORD_MIN   = -32768;

	// floor divide by 6 through a reciprocal multiply
	localparam int DIV_W       = R_W + 2;
	localparam int DIV6_BIAS   = 6 * (2 ** (R_W - 1));
	localparam int DIV6_SHIFT  = 26;
	localparam int DIV6_MUL_W  = 24;
	localparam logic [DIV6_MUL_W-1:0] DIV6_MUL =
		DIV6_MUL_W'(((2 ** DIV6_SHIFT) + 5) / 6);

	typedef struct packed {
		logic                       req_type;
		logic [PT_IDX_W-1:0]        point_index;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
		logic signed [COORD_W-1:0]  coord_z;
		logic [T_W-1:0]             param_t;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] curve_x;
		logic signed [COORD_W-1:0] curve_y;
		logic signed [COORD_W-1:0] curve_z;
	} rsp_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] d;
	} coef_t;

	typedef struct packed {
		logic                       spline;
		logic [T_W-1:0]             t;
		coef_t [NUM_AXES-1:0]       coef;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* rtl/ccpe_queue.sv */
// Short job queue between the front and the back of the evaluator.
// Depends on ccpe_pkg (job_t, qstat_t).
module ccpe_queue #(
	parameter int DEPTH = ccpe_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ccpe_pkg::job_t    push_job,
	input  logic              pop,
	output ccpe_pkg::job_t    head,
	output ccpe_pkg::qstat_t  stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ccpe_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/ccpe_front.sv */
// Front end: request intake, control point store, basis register, and
// power-basis coefficient setup per evaluate beat. Depends on ccpe_pkg.
module ccpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ccpe_pkg::req_t    req_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  ccpe_pkg::qstat_t  qstat,
	output logic              push,
	output ccpe_pkg::job_t    push_job
);

	localparam int CW = ccpe_pkg::COORD_W;
	localparam int EW = ccpe_pkg::COEF_W;

	logic signed [CW-1:0] px_q [ccpe_pkg::NUM_POINTS];
	logic signed [CW-1:0] py_q [ccpe_pkg::NUM_POINTS];
	logic signed [CW-1:0] pz_q [ccpe_pkg::NUM_POINTS];
	logic                 mode_q;
	logic                 accept;
	logic                 spline;

	function automatic ccpe_pkg::coef_t make_coef(
		input logic                 spl,
		input logic signed [CW-1:0] p0,
		input logic signed [CW-1:0] p1,
		input logic signed [CW-1:0] p2,
		input logic signed [CW-1:0] p3
	);
		logic signed [EW-1:0] e0;
		logic signed [EW-1:0] e1;
		logic signed [EW-1:0] e2;
		logic signed [EW-1:0] e3;
		logic signed [EW-1:0] d12;
		logic signed [EW-1:0] s2;
		logic signed [EW-1:0] s1;
		ccpe_pkg::coef_t      r;
		e0  = EW'(p0);
		e1  = EW'(p1);
		e2  = EW'(p2);
		e3  = EW'(p3);
		d12 = e1 - e2;
		r.a = e3 - e0 + (d12 <<< 1) + d12;
		s2  = e0 - (e1 <<< 1) + e2;
		r.b = (s2 <<< 1) + s2;
		if (spl) begin
			s1  = e2 - e0;
			r.d = e0 + (e1 <<< 2) + e2;
		end else begin
			s1  = e1 - e0;
			r.d = e0;
		end
		r.c = (s1 <<< 1) + s1;
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign req_stall = qstat.full;
	assign accept    = req_valid && !qstat.full;
	assign spline    = (mode_q == ccpe_pkg::BASIS_SPLINE);
	assign push      = accept && (req_data.req_type == ccpe_pkg::REQ_EVAL);

	always_comb begin
		push_job.spline  = spline;
		push_job.t       = (req_data.param_t > ccpe_pkg::T_ONE) ? ccpe_pkg::T_ONE
		                                                        : req_data.param_t;
		push_job.coef[0] = make_coef(spline, px_q[0], px_q[1], px_q[2], px_q[3]);
		push_job.coef[1] = make_coef(spline, py_q[0], py_q[1], py_q[2], py_q[3]);
		push_job.coef[2] = make_coef(spline, pz_q[0], pz_q[1], pz_q[2], pz_q[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ccpe_pkg::BASIS_BEZIER;
			for (int i = 0; i < ccpe_pkg::NUM_POINTS; i++) begin
				px_q[i] <= '0;
				py_q[i] <= '0;
				pz_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (accept && (req_data.req_type == ccpe_pkg::REQ_LOAD)) begin
				px_q[req_data.point_index] <= req_data.coord_x;
				py_q[req_data.point_index] <= req_data.coord_y;
				pz_q[req_data.point_index] <= req_data.coord_z;
			end
		end
	end

endmodule

/* rtl/ccpe_back.sv */
// Back end: Horner evaluation pipeline (split products), rounding, divide by
// six for the spline basis, saturation and result register. Depends on ccpe_pkg.
module ccpe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ccpe_pkg::qstat_t  qstat,
	input  ccpe_pkg::job_t    head,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ccpe_pkg::rsp_t    rsp_data
);

	localparam int NA   = ccpe_pkg::NUM_AXES;
	localparam int EW   = ccpe_pkg::COEF_W;
	localparam int TW   = ccpe_pkg::T_W;
	localparam int TF   = ccpe_pkg::T_FRAC;
	localparam int H1W  = ccpe_pkg::H1W;
	localparam int H2W  = ccpe_pkg::H2W;
	localparam int H3W  = ccpe_pkg::H3W;
	localparam int S1   = ccpe_pkg::SPLIT1;
	localparam int S2   = ccpe_pkg::SPLIT2;
	localparam int RW   = ccpe_pkg::R_W;
	localparam int DW   = ccpe_pkg::DIV_W;
	localparam int MW   = ccpe_pkg::DIV6_MUL_W;
	localparam int CW   = ccpe_pkg::COORD_W;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rsp_valid_q;

	// stage 1
	logic signed [H1W-1:0]            h1_d   [NA];
	logic signed [H1W-1:0]            h1_s1  [NA];
	logic signed [EW-1:0]             c_s1   [NA];
	logic signed [EW-1:0]             d_s1   [NA];
	logic [TW-1:0]                    t_s1;
	logic                             spline_s1;
	// stage 2
	logic signed [ccpe_pkg::P2H_W-1:0] p2h_d  [NA];
	logic [ccpe_pkg::P2L_W-1:0]        p2l_d  [NA];
	logic signed [ccpe_pkg::P2H_W-1:0] p2h_s2 [NA];
	logic [ccpe_pkg::P2L_W-1:0]        p2l_s2 [NA];
	logic signed [EW-1:0]              c_s2   [NA];
	logic signed [EW-1:0]              d_s2   [NA];
	logic [TW-1:0]                     t_s2;
	logic                              spline_s2;
	// stage 3
	logic signed [H2W-1:0]             h2_d   [NA];
	logic signed [H2W-1:0]             h2_s3  [NA];
	logic signed [EW-1:0]              d_s3   [NA];
	logic [TW-1:0]                     t_s3;
	logic                              spline_s3;
	// stage 4
	logic signed [ccpe_pkg::P3H_W-1:0] p3h_d  [NA];
	logic [ccpe_pkg::P3L_W-1:0]        p3l_d  [NA];
	logic signed [EW:0]                dr_d   [NA];
	logic [H3W-1:0]                    dt_d   [NA];
	logic signed [ccpe_pkg::P3H_W-1:0] p3h_s4 [NA];
	logic [ccpe_pkg::P3L_W-1:0]        p3l_s4 [NA];
	logic [H3W-1:0]                    dt_s4  [NA];
	logic                              spline_s4;
	// stage 5
	logic signed [H3W-1:0]             h3_d   [NA];
	logic signed [RW-1:0]              r_s5   [NA];
	logic                              spline_s5;
	// output stage
	logic [DW-1:0]                     vo_d   [NA];
	logic [DW+MW-1:0]                  qp_d   [NA];
	logic signed [RW:0]                sel_d  [NA];
	logic signed [CW-1:0]              sat_d  [NA];
	ccpe_pkg::rsp_t                    rsp_d;
	ccpe_pkg::rsp_t                    rsp_q;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign pop       = adv && !qstat.empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		for (int ax = 0; ax < NA; ax++) begin
			h1_d[ax] = H1W'(head.coef[ax].a * $signed({1'b0, head.t}))
			         + (H1W'(head.coef[ax].b) <<< TF);

			p2h_d[ax] = $signed(h1_s1[ax][H1W-1:S1]) * $signed({1'b0, t_s1});
			p2l_d[ax] = h1_s1[ax][S1-1:0] * t_s1;

			h2_d[ax] = (H2W'(p2h_s2[ax]) <<< S1) + H2W'($signed({1'b0, p2l_s2[ax]}))
			         + (H2W'(c_s2[ax]) <<< (2 * TF));

			p3h_d[ax] = $signed(h2_s3[ax][H2W-1:S2]) * $signed({1'b0, t_s3});
			p3l_d[ax] = h2_s3[ax][S2-1:0] * t_s3;
			dr_d[ax]  = spline_s3 ? (EW + 1)'(d_s3[ax]) + (EW + 1)'(ccpe_pkg::SPLINE_BIAS)
			                      : (EW + 1)'(d_s3[ax]);
			dt_d[ax]  = {RW'(dr_d[ax]), !spline_s3, {(3 * TF - 1){1'b0}}};

			h3_d[ax] = (H3W'(p3h_s4[ax]) <<< S2) + H3W'($signed({1'b0, p3l_s4[ax]}))
			         + $signed(dt_s4[ax]);

			vo_d[ax]  = DW'(r_s5[ax]) + DW'(ccpe_pkg::DIV6_BIAS);
			qp_d[ax]  = vo_d[ax] * ccpe_pkg::DIV6_MUL;
			if (spline_s5) begin
				sel_d[ax] = $signed({1'b0, qp_d[ax][DW+MW-1:ccpe_pkg::DIV6_SHIFT]})
				          - $signed((RW + 1)'(2 ** (RW - 1)));
			end else begin
				sel_d[ax] = (RW + 1)'(r_s5[ax]);
			end
			if (sel_d[ax] > ccpe_pkg::COORD_MAX) begin
				sat_d[ax] = CW'(ccpe_pkg::COORD_MAX);
			end else if (sel_d[ax] < ccpe_pkg::COORD_MIN) begin
				sat_d[ax] = CW'(ccpe_pkg::COORD_MIN);
			end else begin
				sat_d[ax] = CW'(sel_d[ax]);
			end
		end
		rsp_d.curve_x = sat_d[0];
		rsp_d.curve_y = sat_d[1];
		rsp_d.curve_z = sat_d[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1      <= head.t;
			spline_s1 <= head.spline;
			t_s2      <= t_s1;
			spline_s2 <= spline_s1;
			t_s3      <= t_s2;
			spline_s3 <= spline_s2;
			spline_s4 <= spline_s3;
			spline_s5 <= spline_s4;
			rsp_q     <= rsp_d;
			for (int ax = 0; ax < NA; ax++) begin
				h1_s1[ax]  <= h1_d[ax];
				c_s1[ax]   <= head.coef[ax].c;
				d_s1[ax]   <= head.coef[ax].d;
				p2h_s2[ax] <= p2h_d[ax];
				p2l_s2[ax] <= p2l_d[ax];
				c_s2[ax]   <= c_s1[ax];
				d_s2[ax]   <= d_s1[ax];
				h2_s3[ax]  <= h2_d[ax];
				d_s3[ax]   <= d_s2[ax];
				p3h_s4[ax] <= p3h_d[ax];
				p3l_s4[ax] <= p3l_d[ax];
				dt_s4[ax]  <= dt_d[ax];
				r_s5[ax]   <= h3_d[ax][H3W-1:3*TF];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !qstat.empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			rsp_valid_q <= v_s5;
		end
	end

endmodule

/* rtl/cubic_curve_point_evaluator.sv */
// Cubic Bezier / uniform B-spline point evaluator, top level.
// An evaluate beat passes the queue, stages s1 to s5 and rsp_q before rsp_valid.
// Throughput: one beat per cycle unless rsp_stall holds the pipe or the queue is full.
// Load beats give no result; a 4-entry queue decouples the two ends.
// Reset (arst_n low): control points cleared to zero, Bezier basis, queue and pipe empty.
module cubic_curve_point_evaluator #(
	parameter int QUEUE_DEPTH = ccpe_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ccpe_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ccpe_pkg::rsp_t  rsp_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);

	ccpe_pkg::qstat_t qstat;
	ccpe_pkg::job_t   push_job;
	ccpe_pkg::job_t   head;
	logic             push;
	logic             pop;

	ccpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.push_job  (push_job)
	);

	ccpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	ccpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

/* rtl/ccpe_checker.sv */
// Port-level checker for the evaluator, attached to the top level by bind.
// Depends on ccpe_pkg and on cubic_curve_point_evaluator's port names.
module ccpe_checker #(
	parameter int QUEUE_DEPTH = ccpe_pkg::QUEUE_DEPTH
) (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input ccpe_pkg::req_t  req_data,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input ccpe_pkg::rsp_t  rsp_data,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic            cfg_data
);

	localparam int MAX_OUT = QUEUE_DEPTH + ccpe_pkg::PIPE_STAGES;
	localparam int CNT_W   = $clog2(MAX_OUT + 2);

	logic [CNT_W-1:0] cnt_q;
	logic             eval_acc;
	logic             rsp_acc;

	assign eval_acc = req_valid && !req_stall && (req_data.req_type == ccpe_pkg::REQ_EVAL);
	assign rsp_acc  = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(eval_acc) - CNT_W'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result beat dropped or changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cnt_q != '0)
		else $error("result beat without a pending evaluate");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT))
		else $error("more evaluates in flight than queue and pipe can hold");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> cnt_q >= CNT_W'(QUEUE_DEPTH))
		else $error("request stalled with queue not full of evaluates");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready || $past(cfg_data) == cfg_data || !cfg_valid)
		else $error("configuration beat refused");

endmodule

bind cubic_curve_point_evaluator ccpe_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ccpe_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for cubic_curve_point_evaluator: control point loads, Bezier and
// uniform B-spline evaluation under random sender gaps and receiver stalls.
// Depends on ccpe_pkg and the evaluator RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_BEATS = 680;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ccpe_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ccpe_pkg::rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	logic signed [ccpe_pkg::COORD_W-1:0] ctrl_pt [ccpe_pkg::NUM_POINTS][ccpe_pkg::NUM_AXES];
	logic basis_sel;
	ccpe_pkg::rsp_t pending_points [$];
	ccpe_pkg::rsp_t want_pt;
	int errors = 0;
	int cycles = 0;
	int beats_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	cubic_curve_point_evaluator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// exact weighted sum, then round half up and saturate
	function automatic logic signed [ccpe_pkg::COORD_W-1:0] blend_axis(input int axis,
			input longint wt [ccpe_pkg::NUM_POINTS]);
		logic signed [95:0] acc;
		logic signed [95:0] c_w;
		logic signed [95:0] w_w;
		longint m;
		longint q;
		acc = '0;
		for (int i = 0; i < ccpe_pkg::NUM_POINTS; i++) begin
			c_w = ctrl_pt[i][axis];
			w_w = wt[i];
			acc = acc + c_w * w_w;
		end
		if (basis_sel == ccpe_pkg::BASIS_SPLINE) begin
			acc = acc + (96'sd3 << 48);
			m = longint'(acc >>> 48);
			q = m / 6;
			if (m % 6 != 0 && m < 0)
				q--;
		end else begin
			acc = acc + (96'sd1 << 47);
			q = longint'(acc >>> 48);
		end
		if (q > ccpe_pkg::COORD_MAX)
			q = ccpe_pkg::COORD_MAX;
		if (q < ccpe_pkg::COORD_MIN)
			q = ccpe_pkg::COORD_MIN;
		return ccpe_pkg::COORD_W'(q);
	endfunction

	function automatic ccpe_pkg::rsp_t curve_point(input logic [ccpe_pkg::T_W-1:0] t_raw);
		longint s;
		longint t;
		longint u;
		longint wt [ccpe_pkg::NUM_POINTS];
		ccpe_pkg::rsp_t p;
		s = 65536;
		t = t_raw;
		if (t > s)
			t = s;
		u = s - t;
		if (basis_sel == ccpe_pkg::BASIS_SPLINE) begin
			wt[0] = u * u * u;
			wt[1] = 3 * t * t * t - 6 * t * t * s + 4 * s * s * s;
			wt[2] = -3 * t * t * t + 3 * t * t * s + 3 * t * s * s + s * s * s;
			wt[3] = t * t * t;
		end else begin
			wt[0] = u * u * u;
			wt[1] = 3 * t * u * u;
			wt[2] = 3 * t * t * u;
			wt[3] = t * t * t;
		end
		p.curve_x = blend_axis(0, wt);
		p.curve_y = blend_axis(1, wt);
		p.curve_z = blend_axis(2, wt);
		return p;
	endfunction

	function automatic ccpe_pkg::req_t load_beat(input logic [ccpe_pkg::PT_IDX_W-1:0] idx,
			input logic [ccpe_pkg::COORD_W-1:0] x, input logic [ccpe_pkg::COORD_W-1:0] y,
			input logic [ccpe_pkg::COORD_W-1:0] z);
		ccpe_pkg::req_t r;
		r.req_type    = ccpe_pkg::REQ_LOAD;
		r.point_index = idx;
		r.coord_x     = x;
		r.coord_y     = y;
		r.coord_z     = z;
		r.param_t     = ccpe_pkg::T_W'($urandom);
		return r;
	endfunction

	function automatic ccpe_pkg::req_t eval_beat(input logic [ccpe_pkg::T_W-1:0] t);
		ccpe_pkg::req_t r;
		r.req_type    = ccpe_pkg::REQ_EVAL;
		r.point_index = ccpe_pkg::PT_IDX_W'($urandom);
		r.coord_x     = ccpe_pkg::COORD_W'($urandom);
		r.coord_y     = ccpe_pkg::COORD_W'($urandom);
		r.coord_z     = ccpe_pkg::COORD_W'($urandom);
		r.param_t     = t;
		return r;
	endfunction

	function automatic logic [ccpe_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return ccpe_pkg::COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [ccpe_pkg::T_W-1:0] rand_t();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return ccpe_pkg::T_ONE;
			2: return ccpe_pkg::T_W'($urandom_range(65537, 131071));
			default: return ccpe_pkg::T_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// drive one beat, wait for acceptance, update the expected-point store, then sometimes idle for a random gap
	task automatic issue_beat(input ccpe_pkg::req_t r);
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		beats_sent++;
		if (r.req_type == ccpe_pkg::REQ_LOAD) begin
			ctrl_pt[r.point_index][0] = r.coord_x;
			ctrl_pt[r.point_index][1] = r.coord_y;
			ctrl_pt[r.point_index][2] = r.coord_z;
		end else begin
			pending_points.push_back(curve_point(r.param_t));
		end
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 10);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_basis(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		basis_sel = mode;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point %0d %0d %0d",
					rsp_data.curve_x, rsp_data.curve_y, rsp_data.curve_z));
			end else begin
				want_pt = pending_points.pop_front();
				if (rsp_data.curve_x !== want_pt.curve_x)
					report_mismatch($sformatf("curve_x got %0d want %0d",
						rsp_data.curve_x, want_pt.curve_x));
				if (rsp_data.curve_y !== want_pt.curve_y)
					report_mismatch($sformatf("curve_y got %0d want %0d",
						rsp_data.curve_y, want_pt.curve_y));
				if (rsp_data.curve_z !== want_pt.curve_z)
					report_mismatch($sformatf("curve_z got %0d want %0d",
						rsp_data.curve_z, want_pt.curve_z));
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(30, 250);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= stall_left[0];
		endcase
	end

	task automatic test_reset_state();
		issue_beat(eval_beat('0));
		issue_beat(eval_beat(ccpe_pkg::T_ONE));
		drain_results();
	endtask

	task automatic load_extreme_points();
		issue_beat(load_beat(2'd0, 16'h7fff, 16'h8000, 16'h0000));
		issue_beat(load_beat(2'd1, 16'h8000, 16'h7fff, 16'h0100));
		issue_beat(load_beat(2'd2, 16'h7fff, 16'h7fff, 16'hff00));
		issue_beat(load_beat(2'd3, 16'h8000, 16'h8000, 16'h1234));
	endtask

	task automatic test_bezier_directed();
		write_basis(ccpe_pkg::BASIS_BEZIER);
		load_extreme_points();
		issue_beat(eval_beat('0));
		issue_beat(eval_beat(ccpe_pkg::T_ONE));
		issue_beat(eval_beat(17'd32768));
		issue_beat(eval_beat(17'd1));
		issue_beat(eval_beat(17'd65535));
		issue_beat(eval_beat(17'h1ffff));
		drain_results();
	endtask

	task automatic test_spline_directed();
		write_basis(ccpe_pkg::BASIS_SPLINE);
		issue_beat(eval_beat('0));
		issue_beat(eval_beat(ccpe_pkg::T_ONE));
		issue_beat(eval_beat(17'd32768));
		issue_beat(eval_beat(17'd65537));
		issue_beat(load_beat(2'd2, 16'h8000, 16'h0001, 16'h7fff));
		issue_beat(eval_beat(17'd21845));
		drain_results();
	endtask

	// well-formed curves: up to four loads then a run of evaluates, with stray loads and random basis writes mixed in
	task automatic test_random_curves(input int n_beats);
		int start;
		int next_cfg;
		int n_eval;
		int step;
		int order [ccpe_pkg::NUM_POINTS];
		start = beats_sent;
		next_cfg = beats_sent + 80;
		while (beats_sent - start < n_beats) begin
			if (beats_sent >= next_cfg) begin
				drain_results();
				write_basis(logic'($urandom_range(0, 1)));
				next_cfg = beats_sent + $urandom_range(60, 140);
			end
			order = '{0, 1, 2, 3};
			order.shuffle();
			for (int i = 0; i < ccpe_pkg::NUM_POINTS; i++)
				if ($urandom_range(0, 9) != 0)
					issue_beat(load_beat(ccpe_pkg::PT_IDX_W'(order[i]), rand_coord(),
						rand_coord(), rand_coord()));
			n_eval = $urandom_range(3, 24);
			step = 65536 / n_eval;
			for (int i = 0; i <= n_eval; i++) begin
				if ($urandom_range(0, 15) == 0)
					issue_beat(load_beat(ccpe_pkg::PT_IDX_W'($urandom), rand_coord(),
						rand_coord(), rand_coord()));
				if ($urandom_range(0, 1) == 0)
					issue_beat(eval_beat((i == n_eval) ? ccpe_pkg::T_ONE
					                                   : ccpe_pkg::T_W'(i * step)));
				else
					issue_beat(eval_beat(rand_t()));
			end
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < ccpe_pkg::NUM_POINTS; i++)
			for (int a = 0; a < ccpe_pkg::NUM_AXES; a++)
				ctrl_pt[i][a] = '0;
		basis_sel = ccpe_pkg::BASIS_BEZIER;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_bezier_directed();
		test_spline_directed();
		test_random_curves(RANDOM_BEATS);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/ccpe_pkg.sv
rtl/ccpe_queue.sv
rtl/ccpe_front.sv
rtl/ccpe_back.sv
rtl/cubic_curve_point_evaluator.sv
rtl/ccpe_checker.sv
bench/testbench.sv
